[sv/tct_pkg.sv]
`default_nettype none
package tct_pkg;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [1:0] KIND_ADD_OK   = 2'd0;
    localparam logic [1:0] KIND_ADD_FULL = 2'd1;
    localparam logic [1:0] KIND_UPDATE   = 2'd2;

    // Widest increment the command can carry (Q1.24 at the largest fraction width).
    localparam int INC_MAX_W = 25;

    typedef struct packed {
        logic        action;
        logic [7:0]  target_id;
        logic [31:0] start_value;
        logic [31:0] end_value;
        logic [15:0] duration_ticks;
        logic        curve;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [7:0]  target_ref;
        logic [31:0] value;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic                 action;
        logic [7:0]           target_id;
        logic [31:0]          origin;
        logic [32:0]          distance;
        logic [INC_MAX_W-1:0] increment;
        logic                 curve;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } link_t;

endpackage
`default_nettype wire

[sv/tween_channel_table.sv]
// Tween channel table.
// Input channel: a transaction is taken on a rising edge with push high and full low.
// An add transaction claims the lowest free slot and returns one result (accepted with
// its slot, or rejected when all slots are busy). A tick transaction advances every
// running channel and returns one value update per channel, lowest slot first; a
// channel that had already reached its end is freed silently. The last result that a
// transaction causes has last set; a tick with no running channel returns nothing.
// Result channel: the oldest result sits on result while empty is low and is taken on
// a rising edge with pop high.
// Flow control: the front raises full while it works on a transaction, so it takes a
// new one only after the last has gone to the command queue; an add first waits for the
// bit-serial divider that forms the per-tick increment.
// Engine steps: an add is handled in B_ADD; a tick takes a start step, a B_SCAN step per
// idle slot, for each running slot three multiplier stages and the output add (B_SCAN,
// B_P1, B_P2, B_P3), and a retire step (B_OUT). The output add waits while a result
// is still held for the receiver.
// When the receiver stalls, results collect in a four-entry queue, then the engine
// holds its output register and waits; the two-entry command queue fills and full
// stays high. Reset marks all channels inactive and empties both queues.
`default_nettype none
module tween_channel_table #(
    parameter int SLOTS     = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire tct_pkg::in_item_t  item,
    output logic                    full,
    output logic                    empty,
    input  wire logic               pop,
    output tct_pkg::out_item_t      result
);
    import tct_pkg::*;

    cmd_t      f_cmd;
    link_t     f_link;
    logic      q_full;
    logic      q_empty;
    cmd_t      q_cmd;
    logic      q_pop;
    out_item_t b_res;
    link_t     b_link;
    logic      o_full;
    logic      front_busy;

    assign full = front_busy;

    tct_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (front_busy),
        .cmd      (f_cmd),
        .cmd_link (f_link),
        .cmd_full (q_full)
    );

    // Short command queue: the front and the engine stall independently.
    tct_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_link.valid && f_link.ready),
        .wr_data (f_cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_cmd),
        .empty   (q_empty)
    );

    // The engine releases a command once it has finished with it.
    tct_back #(.SLOTS(SLOTS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .res       (b_res),
        .res_link  (b_link),
        .res_full  (o_full)
    );

    tct_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(4)) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (b_link.valid && b_link.ready),
        .wr_data (b_res),
        .full    (o_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );
endmodule
`default_nettype wire

[sv/tct_fifo.sv]
`default_nettype none
module tct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;

    logic do_wr;
    logic do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end
endmodule
`default_nettype wire

[sv/tct_front.sv]
`default_nettype none
module tct_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire tct_pkg::in_item_t item,
    output logic                   full,
    output tct_pkg::cmd_t          cmd,
    output tct_pkg::link_t         cmd_link,
    input  wire logic              cmd_full
);
    import tct_pkg::*;

    localparam int NW = FRAC_BITS + 17;
    localparam int CW = $clog2(NW + 1);
    localparam logic [NW-1:0] ONE = NW'(1) << FRAC_BITS;

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

    fstate_t         state_reg;
    in_item_t        item_reg;
    logic [NW-1:0]   num_reg;
    logic [16:0]     rem_reg;
    logic [15:0]     dur_reg;
    logic [CW-1:0]   cnt_reg;

    logic [15:0]     dur_fix;
    logic [16:0]     trial;
    logic [NW-1:0]   inc_clamped;

    assign dur_fix = (item.duration_ticks == '0) ? 16'd1 : item.duration_ticks;
    assign trial   = {rem_reg[15:0], num_reg[NW-1]};
    assign full    = (state_reg != F_IDLE);

    always_comb
    begin
        if (num_reg == '0)
        begin
            inc_clamped = NW'(1);
        end
        else if (num_reg > ONE)
        begin
            inc_clamped = ONE;
        end
        else
        begin
            inc_clamped = num_reg;
        end
    end

    assign cmd.action    = item_reg.action;
    assign cmd.target_id = item_reg.target_id;
    assign cmd.origin    = item_reg.start_value;
    assign cmd.distance  = {item_reg.end_value[31], item_reg.end_value}
                         - {item_reg.start_value[31], item_reg.start_value};
    assign cmd.increment = INC_MAX_W'(inc_clamped[FRAC_BITS:0]);
    assign cmd.curve     = item_reg.curve;
    assign cmd_link.valid = (state_reg == F_PUSH);
    assign cmd_link.ready = !cmd_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        item_reg <= item;
                        dur_reg  <= dur_fix;
                        num_reg  <= ONE + NW'(dur_fix >> 1);
                        rem_reg  <= '0;
                        cnt_reg  <= CW'(NW);
                        state_reg <= (item.action == ACT_ADD) ? F_DIV : F_PUSH;
                    end
                end
                F_DIV:
                begin
                    // One quotient bit per cycle, restoring division.
                    if (trial >= {1'b0, dur_reg})
                    begin
                        rem_reg <= trial - {1'b0, dur_reg};
                        num_reg <= {num_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial;
                        num_reg <= {num_reg[NW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!cmd_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/tct_back.sv]
`default_nettype none
module tct_back #(
    parameter int SLOTS     = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tct_pkg::cmd_t  cmd,
    input  wire logic           cmd_empty,
    output logic                cmd_pop,
    output tct_pkg::out_item_t  res,
    output tct_pkg::link_t      res_link,
    input  wire logic           res_full
);
    import tct_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int XW = FRAC_BITS + 1;
    localparam int PW = 33 + XW + 1;
    localparam int VW = PW - FRAC_BITS + 1;
    localparam logic [XW:0] ONE = (XW+1)'(1) << FRAC_BITS;

    typedef enum logic [2:0] {B_IDLE, B_ADD, B_SCAN, B_P1, B_P2, B_P3, B_OUT} bstate_t;

    bstate_t            state_reg;
    logic [SLOTS-1:0]   active_reg;
    logic [SLOTS-1:0]   emit_reg;
    logic [7:0]         tgt_reg   [SLOTS];
    logic [31:0]        org_reg   [SLOTS];
    logic [32:0]        dist_reg  [SLOTS];
    logic [XW-1:0]      inc_reg   [SLOTS];
    logic [XW-1:0]      prog_reg  [SLOTS];
    logic               crv_reg   [SLOTS];
    logic [SW-1:0]      idx_reg;
    logic [XW-1:0]      x_reg;
    logic [2*XW-1:0]    sq_reg;
    logic [2*XW+2:0]    m2_reg;
    logic signed [PW-1:0] prod_reg;
    out_item_t          res_reg;
    logic               res_valid_reg;

    logic [SLOTS-1:0]   emit_now;
    logic               free_any;
    logic [SW-1:0]      free_idx;
    logic               more_after;
    logic [XW:0]        p_sum;
    logic [XW-1:0]      p_new;
    logic [XW-1:0]      x2;
    logic [XW+1:0]      tfac;
    logic [2*XW+2:0]    s_round;
    logic [XW-1:0]      s_val;
    logic signed [PW-1:0] prod_next;
    logic signed [PW:0]   prod_rnd;
    logic signed [VW-1:0] v_full;

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int j = SLOTS - 1; j >= 0; j--)
        begin
            if (!active_reg[j])
            begin
                free_any = 1'b1;
                free_idx = SW'(j);
            end
        end
        more_after = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            emit_now[j] = active_reg[j] && ({1'b0, prog_reg[j]} < ONE);
            if ((SW'(j) > idx_reg) && emit_reg[j])
            begin
                more_after = 1'b1;
            end
        end
    end

    assign p_sum   = {1'b0, prog_reg[idx_reg]} + {1'b0, inc_reg[idx_reg]};
    assign p_new   = (p_sum > ONE) ? XW'(ONE) : p_sum[XW-1:0];
    assign x2      = XW'((sq_reg + (2*XW)'(ONE >> 1)) >> FRAC_BITS);
    assign tfac    = (XW+2)'(3) * (XW+2)'(ONE) - {x_reg, 1'b0};
    assign s_round = (m2_reg + (2*XW+3)'(ONE >> 1)) >> FRAC_BITS;

    always_comb
    begin
        if (!crv_reg[idx_reg])
        begin
            s_val = x_reg;
        end
        else if (s_round > (2*XW+3)'(ONE))
        begin
            s_val = XW'(ONE);
        end
        else
        begin
            s_val = s_round[XW-1:0];
        end
    end

    assign prod_next = $signed(dist_reg[idx_reg]) * $signed({1'b0, s_val});
    assign prod_rnd  = (PW+1)'(prod_reg) + (PW+1)'(ONE >> 1);
    assign v_full    = VW'(prod_rnd >>> FRAC_BITS)
                     + VW'($signed(org_reg[idx_reg]));

    // The command leaves the queue when the engine finishes with it: in B_ADD, or in B_OUT after a tick.
    assign cmd_pop        = (state_reg == B_ADD) || (state_reg == B_OUT);
    assign res            = res_reg;
    assign res_link.valid = res_valid_reg;
    assign res_link.ready = !res_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            active_reg    <= '0;
            emit_reg      <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && !res_full && state_reg != B_P3)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!cmd_empty && !res_valid_reg)
                    begin
                        if (cmd.action == ACT_ADD)
                        begin
                            state_reg <= B_ADD;
                        end
                        else
                        begin
                            // Finished channels are freed; the rest are walked in order.
                            emit_reg   <= emit_now;
                            active_reg <= emit_now;
                            idx_reg    <= '0;
                            state_reg  <= B_SCAN;
                        end
                    end
                end
                B_ADD:
                begin
                    res_reg.target_ref <= cmd.target_id;
                    res_reg.value      <= '0;
                    res_reg.last       <= 1'b1;
                    res_valid_reg      <= 1'b1;
                    if (free_any)
                    begin
                        active_reg[free_idx] <= 1'b1;
                        tgt_reg[free_idx]    <= cmd.target_id;
                        org_reg[free_idx]    <= cmd.origin;
                        dist_reg[free_idx]   <= cmd.distance;
                        inc_reg[free_idx]    <= cmd.increment[XW-1:0];
                        prog_reg[free_idx]   <= '0;
                        crv_reg[free_idx]    <= cmd.curve;
                        res_reg.kind         <= KIND_ADD_OK;
                        res_reg.slot         <= 4'(free_idx);
                    end
                    else
                    begin
                        res_reg.kind <= KIND_ADD_FULL;
                        res_reg.slot <= '0;
                    end
                    state_reg <= B_IDLE;
                end
                B_SCAN:
                begin
                    if (emit_reg[idx_reg])
                    begin
                        prog_reg[idx_reg] <= p_new;
                        x_reg  <= p_new;
                        sq_reg <= p_new * p_new;
                        state_reg <= B_P1;
                    end
                    else if (idx_reg == SW'(SLOTS - 1))
                    begin
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                B_P1:
                begin
                    m2_reg    <= (2*XW+3)'(x2) * (2*XW+3)'(tfac);
                    state_reg <= B_P2;
                end
                B_P2:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= B_P3;
                end
                B_P3:
                begin
                    if (!res_valid_reg || !res_full)
                    begin
                        res_reg.kind       <= KIND_UPDATE;
                        res_reg.slot       <= 4'(idx_reg);
                        res_reg.target_ref <= tgt_reg[idx_reg];
                        res_reg.last       <= !more_after;
                        if (v_full > VW'(32'sh7FFF_FFFF))
                        begin
                            res_reg.value <= 32'h7FFF_FFFF;
                        end
                        else if (v_full < -VW'(33'sh0_8000_0000))
                        begin
                            res_reg.value <= 32'h8000_0000;
                        end
                        else
                        begin
                            res_reg.value <= v_full[31:0];
                        end
                        res_valid_reg <= 1'b1;
                        if (idx_reg == SW'(SLOTS - 1))
                        begin
                            state_reg <= B_OUT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= B_SCAN;
                        end
                    end
                end
                B_OUT:
                begin
                    // Tick finished: retire the command.
                    state_reg <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
            if (state_reg == B_OUT)
            begin
                emit_reg <= '0;
            end
        end
    end
endmodule
`default_nettype wire

[sv/tct_checker.sv]
`default_nettype none
module tct_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire tct_pkg::out_item_t result
);
    import tct_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.kind == KIND_ADD_OK || result.kind == KIND_ADD_FULL
                    || result.kind == KIND_UPDATE))
        else $error("bad result kind");

    a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_UPDATE) |-> (result.last && result.value == '0))
        else $error("add result malformed");

    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_ADD_FULL) |-> (result.slot == '0))
        else $error("rejected add carries a slot");
endmodule

bind tween_channel_table tct_checker u_tct_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the tween channel table.
// A behavioural predictor keeps its own copy of the channel table and works out the
// results of every accepted transaction. A separate process compares each popped
// result, field by field, with the oldest prediction.
module testbench;
    import tct_pkg::*;

    localparam int NSLOT = 16;
    localparam int FRACB = 16;
    localparam longint UNIT = 64'd1 << FRACB;

    logic      clk;
    logic      rst_n;
    logic      push;
    in_item_t  item;
    logic      full;
    logic      empty;
    logic      pop;
    out_item_t result;

    tween_channel_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // The predictor's copy of the channel table.
    bit              chan_busy [NSLOT];
    logic [7:0]      chan_target [NSLOT];
    longint          chan_origin [NSLOT];
    longint          chan_span [NSLOT];
    longint unsigned chan_step [NSLOT];
    longint unsigned chan_pos [NSLOT];
    bit              chan_smooth [NSLOT];

    out_item_t pending_results[$];
    int        mismatch_count;
    int        popped_count;
    bit        long_stall;
    bit        gaps_on;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Easing curve applied to a Q1.16 progress value.
    function automatic longint unsigned ease(longint unsigned x, bit smooth);
        longint unsigned x2;
        longint unsigned s;
        if (!smooth)
            return x;
        x2 = (x * x + (UNIT >> 1)) >> FRACB;
        s = (x2 * (3 * UNIT - 2 * x) + (UNIT >> 1)) >> FRACB;
        return (s > UNIT) ? UNIT : s;
    endfunction

    // Advances the predicted table by one transaction and queues the results it causes.
    function automatic void predict_tween(in_item_t it);
        out_item_t r;
        int        slot_idx;
        int        n;
        longint unsigned dur;
        longint unsigned inc;
        longint unsigned s;
        longint    v;
        if (it.action == ACT_ADD) begin
            slot_idx = -1;
            for (int i = NSLOT - 1; i >= 0; i--)
                if (!chan_busy[i])
                    slot_idx = i;
            r = '0;
            r.target_ref = it.target_id;
            r.last = 1'b1;
            if (slot_idx < 0) begin
                r.kind = KIND_ADD_FULL;
            end
            else begin
                dur = (it.duration_ticks == 0) ? 1 : it.duration_ticks;
                inc = (UNIT + (dur >> 1)) / dur;
                if (inc == 0)
                    inc = 1;
                if (inc > UNIT)
                    inc = UNIT;
                chan_busy[slot_idx] = 1'b1;
                chan_target[slot_idx] = it.target_id;
                chan_origin[slot_idx] = longint'(signed'(it.start_value));
                chan_span[slot_idx] = longint'(signed'(it.end_value)) - chan_origin[slot_idx];
                chan_step[slot_idx] = inc;
                chan_pos[slot_idx] = 0;
                chan_smooth[slot_idx] = it.curve;
                r.kind = KIND_ADD_OK;
                r.slot = slot_idx[3:0];
            end
            pending_results = {pending_results, r};
        end
        else begin
            n = 0;
            for (int i = 0; i < NSLOT; i++) begin
                if (!chan_busy[i])
                    continue;
                if (chan_pos[i] >= UNIT) begin
                    chan_busy[i] = 1'b0;
                    continue;
                end
                chan_pos[i] = chan_pos[i] + chan_step[i];
                if (chan_pos[i] > UNIT)
                    chan_pos[i] = UNIT;
                s = ease(chan_pos[i], chan_smooth[i]);
                // Arithmetic shift gives the floor of the rounded product.
                v = chan_origin[i] + ((chan_span[i] * longint'(s) + longint'(UNIT >> 1))
                    >>> FRACB);
                if (v > 64'sd2147483647)
                    v = 64'sd2147483647;
                if (v < -64'sd2147483648)
                    v = -64'sd2147483648;
                r = '0;
                r.kind = KIND_UPDATE;
                r.slot = i[3:0];
                r.target_ref = chan_target[i];
                r.value = v[31:0];
                pending_results = {pending_results, r};
                n++;
            end
            if (n > 0)
                pending_results[pending_results.size() - 1].last = 1'b1;
        end
    endfunction

    // Offers one transaction, holds it until accepted, and predicts its results.
    // Gaps between bursts are inserted here when gaps_on is set; push stays high
    // after acceptance so that back-to-back transactions need no idle cycle.
    int burst_left;

    task automatic send_item(in_item_t it);
        int gap;
        gap = 0;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(0, 8);
            end
            burst_left--;
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_tween(it);
    endtask

    // Withdraws the offer once a sequence of transactions is complete.
    task automatic stop_sending();
        push <= 1'b0;
        @(posedge clk);
    endtask

    function automatic in_item_t make_add(logic [7:0] tid, logic [31:0] sv, logic [31:0] ev,
                                          logic [15:0] dur, logic crv);
        in_item_t it;
        it.action = ACT_ADD;
        it.target_id = tid;
        it.start_value = sv;
        it.end_value = ev;
        it.duration_ticks = dur;
        it.curve = crv;
        return it;
    endfunction

    function automatic in_item_t make_tick();
        in_item_t it;
        it = make_add(8'($urandom), $urandom, $urandom, 16'($urandom), 1'($urandom));
        it.action = ACT_TICK;
        return it;
    endfunction

    function automatic in_item_t random_add();
        logic [15:0] dur;
        // Mostly short tweens so that channels finish and slots get reused.
        case ($urandom_range(0, 9))
            0:       dur = 16'($urandom);
            1:       dur = 16'd0;
            default: dur = 16'($urandom_range(1, 12));
        endcase
        return make_add(8'($urandom), $urandom, $urandom, dur, 1'($urandom));
    endfunction

    // Receiver: stalls on its own pattern, with one long hold-off on request.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            pop <= 1'b0;
        else if (long_stall)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 3) != 0) || !gaps_on;
    end

    // Checker: compares each accepted result with the oldest prediction.
    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && pop && !empty) begin
            popped_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: %p", result);
            end
            else begin
                want = pending_results.pop_front();
                if (result.kind !== want.kind || result.slot !== want.slot
                    || result.target_ref !== want.target_ref
                    || result.value !== want.value || result.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %p, actual %p", want, result);
                end
            end
        end
    end

    // Directed test: field extremes, both curves, zero and long durations.
    task automatic test_extremes();
        send_item(make_add(8'h00, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 1'b0));
        send_item(make_add(8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1, 1'b1));
        send_item(make_add(8'h5A, 32'h0001_0000, 32'hFFFF_0000, 16'hFFFF, 1'b1));
        send_item(make_add(8'hA5, 32'h0000_0000, 32'h0003_0000, 16'd3, 1'b0));
        send_item(make_add(8'h3C, 32'hFFFF_FFFF, 32'h0000_0001, 16'd2, 1'b1));
        repeat (4)
            send_item(make_tick());
    endtask

    // Directed test: fill the table, get adds rejected, then tick until the short channels are freed.
    task automatic test_table_full();
        for (int i = 0; i < NSLOT + 2; i++)
            send_item(make_add(i[7:0], $urandom, $urandom, 16'd2, i[0]));
        repeat (4)
            send_item(make_tick());
        send_item(make_tick());
    endtask

    // Random mixture of adds and ticks, sent in bursts with gaps.
    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 2) == 0)
                send_item(random_add());
            else
                send_item(make_tick());
        end
    endtask

    // Long receiver hold-off while the sender keeps offering, waiting whenever the block raises full.
    task automatic test_backpressure();
        fork
            begin
                long_stall <= 1'b1;
                repeat (400) @(posedge clk);
                long_stall <= 1'b0;
            end
            begin
                for (int i = 0; i < 60; i++)
                    send_item((i % 3 == 0) ? random_add() : make_tick());
                stop_sending();
            end
        join
    endtask

    task automatic drain_results();
        stop_sending();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial begin
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        mismatch_count = 0;
        popped_count = 0;
        long_stall = 1'b0;
        gaps_on = 1'b0;
        burst_left = 0;
        for (int i = 0; i < NSLOT; i++)
            chan_busy[i] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_table_full();
        gaps_on = 1'b1;
        test_random(200);
        test_backpressure();
        test_random(200);
        drain_results();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
